>>> src/decimating_fir_filter_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the decimating FIR filter core.
// Shared helpers for concurrent checks on clocked logic.
// ---------------------------------------------------------------------------
`ifndef DECIMATING_FIR_FILTER_CORE_DEFINES_SVH
`define DECIMATING_FIR_FILTER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DFF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DFF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dff_pkg.sv
// ---------------------------------------------------------------------------
// Decimating FIR filter package
// Sizes, beat types and internal request structs shared by the filter core.
// ---------------------------------------------------------------------------
package dff_pkg;

    localparam int TAPS         = 64;
    localparam int MAX_CHANNELS = 8;

    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1) + 1;
    localparam int ADDR_W = (MAX_CHANNELS * TAPS > 1) ? $clog2(MAX_CHANNELS * TAPS) : 1;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_IDX_W = 6;
    localparam int OUT_CH_W   = 3;
    localparam int ACC_W      = 40;
    localparam int FRAC_W     = 15;
    localparam int ROUND_BIAS = 1 << (FRAC_W - 1);

    localparam int RATIO_W    = 7;
    localparam int PHASE_W    = 6;
    localparam int MAX_RATIO  = 64;
    localparam int CFG_CH_W   = 4;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 1'd1;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    typedef struct packed {
        logic                         func;
        logic signed [SAMPLE_W-1:0]   sample_value;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic signed [SAMPLE_W-1:0]   coef_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_value;
        logic [OUT_CH_W-1:0]        out_channel;
    } out_beat_t;

    typedef struct packed {
        logic                       valid;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] data;
    } sample_wr_t;

    typedef struct packed {
        logic                       valid;
        logic [COEF_IDX_W-1:0]      index;
        logic signed [SAMPLE_W-1:0] data;
    } coef_wr_t;

    typedef struct packed {
        logic             valid;
        logic [CH_W-1:0]  ch;
        logic [TAP_W-1:0] tap;
    } tap_req_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

>>> src/decimating_fir_filter_core.sv
// A sample that yields a result reads every tap in RUN, one tap read per cycle from the sample
// and coefficient RAMs into the single multiply-accumulate unit, waits in DRAIN for the MAC,
// then hands its result to the m_ output register from DONE once that is free; s_ready is low meanwhile.
// Coefficient writes and samples in dropped frames leave the core in IDLE.
// Reset (aresetn low, synchronous) clears control state; all taps read as zero
// until written, with no clearing pass.
// ---------------------------------------------------------------------------
// Decimating FIR filter core
// Multichannel Q1.15 FIR with frame decimation, built around sample and
// coefficient RAMs walked tap by tap through one multiply-accumulate unit.
// ---------------------------------------------------------------------------
`include "decimating_fir_filter_core_defines.svh"

module decimating_fir_filter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dff_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dff_pkg::out_beat_t                m_data,
    input  logic                              cfg_we,
    input  logic [dff_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dff_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic [dff_pkg::TAP_W-1:0]         tap_reg, tap_next;
    logic [dff_pkg::CH_W-1:0]          ch_reg, ch_next;
    logic [dff_pkg::CH_W-1:0]          pos_reg, pos_next;
    logic [dff_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [dff_pkg::RATIO_W-1:0]       ratio_reg, ratio_next;
    logic [dff_pkg::CFG_CH_W-1:0]      chans_reg, chans_next;
    logic                              rd_valid_reg, rd_valid_next;
    logic                              m_valid_reg, m_valid_next;
    dff_pkg::out_beat_t                m_data_reg, m_data_next;

    logic [dff_pkg::RATIO_W-1:0]       ratio_eff;
    logic [dff_pkg::CNT_W-1:0]         chans_eff;
    logic [dff_pkg::CH_W-1:0]          ch_sel;
    logic [dff_pkg::RATIO_W-1:0]       phase_inc;
    logic                              accept;
    logic                              push;
    logic                              produce;
    logic                              frame_end;
    logic                              out_free;

    dff_pkg::sample_wr_t               sample_wr;
    dff_pkg::coef_wr_t                 coef_wr;
    dff_pkg::tap_req_t                 tap_rd;
    dff_pkg::mac_ctrl_t                mac_ctrl;
    logic signed [dff_pkg::SAMPLE_W-1:0] sample_q;
    logic signed [dff_pkg::SAMPLE_W-1:0] coef_q;
    logic                              mac_busy;
    logic signed [dff_pkg::SAMPLE_W-1:0] mac_result;

    always_comb begin
        if (ratio_reg == '0) begin
            ratio_eff = dff_pkg::RATIO_W'(1);
        end else if (ratio_reg > dff_pkg::RATIO_W'(dff_pkg::MAX_RATIO)) begin
            ratio_eff = dff_pkg::RATIO_W'(dff_pkg::MAX_RATIO);
        end else begin
            ratio_eff = ratio_reg;
        end
        if (chans_reg == '0) begin
            chans_eff = dff_pkg::CNT_W'(1);
        end else if (int'(chans_reg) > dff_pkg::MAX_CHANNELS) begin
            chans_eff = dff_pkg::CNT_W'(dff_pkg::MAX_CHANNELS);
        end else begin
            chans_eff = dff_pkg::CNT_W'(chans_reg);
        end
        ch_sel    = (dff_pkg::CNT_W'(pos_reg) >= chans_eff) ? '0 : pos_reg;
        frame_end = (dff_pkg::CNT_W'(ch_sel) + dff_pkg::CNT_W'(1)) >= chans_eff;
        phase_inc = dff_pkg::RATIO_W'(phase_reg) + dff_pkg::RATIO_W'(1);
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign push     = accept && (s_data.func == dff_pkg::FUNC_SAMPLE);
    assign produce  = (phase_reg == '0);
    assign out_free = !m_valid_reg || m_ready;

    assign sample_wr.valid = push;
    assign sample_wr.ch    = ch_sel;
    assign sample_wr.data  = s_data.sample_value;

    assign coef_wr.valid = accept && (s_data.func == dff_pkg::FUNC_COEF);
    assign coef_wr.index = s_data.coef_index;
    assign coef_wr.data  = s_data.coef_value;

    assign tap_rd.valid = (state_reg == ST_RUN);
    assign tap_rd.ch    = ch_reg;
    assign tap_rd.tap   = tap_reg;

    assign mac_ctrl.clear = push && produce;
    assign mac_ctrl.valid = rd_valid_reg;

    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        ch_next       = ch_reg;
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        ratio_next    = ratio_reg;
        chans_next    = chans_reg;
        rd_valid_next = (state_reg == ST_RUN);
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (cfg_we) begin
            case (cfg_index)
                dff_pkg::REG_DECIMATION: begin
                    ratio_next = cfg_wdata;
                    pos_next   = '0;
                    phase_next = '0;
                end
                dff_pkg::REG_CHANNELS: begin
                    chans_next = dff_pkg::CFG_CH_W'(cfg_wdata);
                    pos_next   = '0;
                    phase_next = '0;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (push) begin
                    ch_next  = ch_sel;
                    tap_next = '0;
                    if (produce) begin
                        state_next = ST_RUN;
                    end
                    if (frame_end) begin
                        pos_next   = '0;
                        phase_next = (phase_inc >= ratio_eff)
                                     ? '0 : dff_pkg::PHASE_W'(phase_inc);
                    end else begin
                        pos_next = ch_sel + dff_pkg::CH_W'(1);
                    end
                end
            end
            ST_RUN: begin
                tap_next = tap_reg + dff_pkg::TAP_W'(1);
                if (tap_reg == dff_pkg::TAP_W'(dff_pkg::TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !mac_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.filtered_value = mac_result;
                    m_data_next.out_channel    = dff_pkg::OUT_CH_W'(ch_reg);
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            phase_reg    <= '0;
            ratio_reg    <= dff_pkg::RATIO_W'(1);
            chans_reg    <= dff_pkg::CFG_CH_W'(1);
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            ratio_reg    <= ratio_next;
            chans_reg    <= chans_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tap_reg    <= tap_next;
        ch_reg     <= ch_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    dff_sample_store u_sample_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (sample_wr),
        .rd      (tap_rd),
        .rd_data (sample_q)
    );

    dff_coef_store u_coef_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (coef_wr),
        .rd      (tap_rd),
        .rd_data (coef_q)
    );

    dff_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .sample  (sample_q),
        .coef    (coef_q),
        .busy    (mac_busy),
        .result  (mac_result)
    );

    `DFF_ASSERT_NEXT(a_done_loads_output, aclk, aresetn, (state_reg == ST_DONE) && out_free, m_valid_reg, "Finished result was not loaded into the output register.")
    `DFF_ASSERT_NEXT(a_drain_waits, aclk, aresetn, (state_reg == ST_DRAIN) && rd_valid_reg, state_reg == ST_DRAIN, "Drain ended with a tap read still in flight.")
    `DFF_ASSERT_NEXT(a_dropped_frame_idle, aclk, aresetn, push && !produce, state_reg == ST_IDLE, "Sample of a dropped frame started a filter pass.")

endmodule

>>> src/dff_sample_store.sv
// ---------------------------------------------------------------------------
// Sample store
// Per-channel circular delay lines in one RAM, with write pointers and fill
// counts so that never-written taps read as zero without a clearing pass.
// ---------------------------------------------------------------------------
module dff_sample_store (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dff_pkg::sample_wr_t                wr,
    input  dff_pkg::tap_req_t                  rd,
    output logic signed [dff_pkg::SAMPLE_W-1:0] rd_data
);

    logic signed [dff_pkg::SAMPLE_W-1:0] mem [dff_pkg::MAX_CHANNELS * dff_pkg::TAPS];
    logic [dff_pkg::TAP_W-1:0]  wptr_reg [dff_pkg::MAX_CHANNELS];
    logic [dff_pkg::FILL_W-1:0] fill_reg [dff_pkg::MAX_CHANNELS];
    logic signed [dff_pkg::SAMPLE_W-1:0] q_reg;
    logic                                hit_reg;

    logic [dff_pkg::TAP_W:0]    rd_sum;
    logic [dff_pkg::TAP_W:0]    rd_wrap;
    logic [dff_pkg::ADDR_W-1:0] rd_addr;
    logic [dff_pkg::ADDR_W-1:0] wr_addr;
    logic                       rd_hit;

    // Tap j of a channel sits j places behind the newest sample.
    always_comb begin
        rd_sum  = {1'b0, wptr_reg[rd.ch]} + (dff_pkg::TAP_W + 1)'(dff_pkg::TAPS - 1)
                  - {1'b0, rd.tap};
        rd_wrap = (rd_sum >= (dff_pkg::TAP_W + 1)'(dff_pkg::TAPS))
                  ? rd_sum - (dff_pkg::TAP_W + 1)'(dff_pkg::TAPS) : rd_sum;
        rd_addr = dff_pkg::ADDR_W'(rd.ch) * dff_pkg::ADDR_W'(dff_pkg::TAPS)
                  + dff_pkg::ADDR_W'(rd_wrap);
        wr_addr = dff_pkg::ADDR_W'(wr.ch) * dff_pkg::ADDR_W'(dff_pkg::TAPS)
                  + dff_pkg::ADDR_W'(wptr_reg[wr.ch]);
        rd_hit  = dff_pkg::FILL_W'(rd.tap) < fill_reg[rd.ch];
    end

    always_ff @(posedge aclk) begin
        if (wr.valid) begin
            mem[wr_addr] <= wr.data;
        end
        if (rd.valid) begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dff_pkg::MAX_CHANNELS; i++) begin
                wptr_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            hit_reg <= 1'b0;
        end else begin
            if (wr.valid) begin
                if (wptr_reg[wr.ch] == dff_pkg::TAP_W'(dff_pkg::TAPS - 1)) begin
                    wptr_reg[wr.ch] <= '0;
                end else begin
                    wptr_reg[wr.ch] <= wptr_reg[wr.ch] + dff_pkg::TAP_W'(1);
                end
                if (fill_reg[wr.ch] != dff_pkg::FILL_W'(dff_pkg::TAPS)) begin
                    fill_reg[wr.ch] <= fill_reg[wr.ch] + dff_pkg::FILL_W'(1);
                end
            end
            if (rd.valid) begin
                hit_reg <= rd_hit;
            end
        end
    end

    assign rd_data = hit_reg ? q_reg : '0;

endmodule

>>> src/dff_coef_store.sv
// ---------------------------------------------------------------------------
// Coefficient store
// Tap coefficient RAM with per-entry valid bits; unwritten taps read as zero.
// ---------------------------------------------------------------------------
module dff_coef_store (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dff_pkg::coef_wr_t                  wr,
    input  dff_pkg::tap_req_t                  rd,
    output logic signed [dff_pkg::SAMPLE_W-1:0] rd_data
);

    logic signed [dff_pkg::SAMPLE_W-1:0] mem [dff_pkg::TAPS];
    logic [dff_pkg::TAPS-1:0]            valid_reg;
    logic signed [dff_pkg::SAMPLE_W-1:0] q_reg;
    logic                                hit_reg;
    logic                                wr_ok;
    logic [dff_pkg::TAP_W-1:0]           wr_idx;

    assign wr_ok  = wr.valid && (int'(wr.index) < dff_pkg::TAPS);
    assign wr_idx = dff_pkg::TAP_W'(wr.index);

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_idx] <= wr.data;
        end
        if (rd.valid) begin
            q_reg <= mem[rd.tap];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (wr_ok) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd.valid) begin
                hit_reg <= valid_reg[rd.tap];
            end
        end
    end

    assign rd_data = hit_reg ? q_reg : '0;

endmodule

>>> src/dff_mac.sv
// ---------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered 16x16 product into a 40-bit accumulator, with rounding,
// Q1.15 rescaling and saturation of the final sum.
// ---------------------------------------------------------------------------
module dff_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dff_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [dff_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [dff_pkg::SAMPLE_W-1:0] coef,
    output logic                                busy,
    output logic signed [dff_pkg::SAMPLE_W-1:0] result
);

    localparam int SH_W = dff_pkg::ACC_W - dff_pkg::FRAC_W;
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
    localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(32768);

    logic signed [2*dff_pkg::SAMPLE_W-1:0] prod_reg;
    logic                                  prod_valid_reg;
    logic signed [dff_pkg::ACC_W-1:0]      acc_reg;
    logic signed [dff_pkg::ACC_W-1:0]      rounded;
    logic signed [SH_W-1:0]                shifted;

    always_ff @(posedge aclk) begin
        if (ctrl.valid) begin
            prod_reg <= sample * coef;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end else begin
            prod_valid_reg <= ctrl.valid;
            if (ctrl.clear) begin
                acc_reg <= '0;
            end else if (prod_valid_reg) begin
                acc_reg <= acc_reg + dff_pkg::ACC_W'(prod_reg);
            end
        end
    end

    always_comb begin
        rounded = acc_reg + dff_pkg::ACC_W'(dff_pkg::ROUND_BIAS);
        shifted = rounded[dff_pkg::ACC_W-1:dff_pkg::FRAC_W];
        if (shifted > SAT_HI) begin
            result = 16'sh7fff;
        end else if (shifted < SAT_LO) begin
            result = -16'sh8000;
        end else begin
            result = dff_pkg::SAMPLE_W'(shifted);
        end
    end

    assign busy = prod_valid_reg;

endmodule
